// File: rtl/marker_code_rotation_matcher_core_macros.svh
// ----------------------------------------------------------------------------
// marker_code_rotation_matcher_core_macros.svh
// assertion macros for the marker code matcher; empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef MARKER_CODE_ROTATION_MATCHER_CORE_MACROS_SVH
`define MARKER_CODE_ROTATION_MATCHER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// condition holds in the same cycle
`define MCRM_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: label");

// condition leads to property in the next cycle
`define MCRM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: label");

`else

`define MCRM_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define MCRM_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// File: rtl/mcrm_pkg.sv
// ----------------------------------------------------------------------------
// mcrm_pkg
// types, register indexes, reset values and bit helpers for the matcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcrm_pkg;

    localparam int CodeWidth   = 16;
    localparam int DistWidth   = 5;
    localparam int SlotCount   = 4;
    localparam int TurnCount   = 4;
    localparam int CandCount   = SlotCount * TurnCount;
    localparam int CandWidth   = $clog2(CandCount);
    localparam int SlotWidth   = $clog2(SlotCount);
    localparam int TurnWidth   = $clog2(TurnCount);
    localparam int CfgIdxWidth = 3;

    typedef logic [CodeWidth-1:0]   code_t;
    typedef logic [DistWidth-1:0]   dist_t;
    typedef logic [CandWidth-1:0]   cand_t;
    typedef logic [SlotWidth-1:0]   slot_t;
    typedef logic [TurnWidth-1:0]   turn_t;
    typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_PATTERN_ZERO  = 3'd0,
        REG_PATTERN_ONE   = 3'd1,
        REG_PATTERN_TWO   = 3'd2,
        REG_PATTERN_THREE = 3'd3,
        REG_MAX_DISTANCE  = 3'd4
    } reg_idx_t;

    localparam code_t PATTERN_ZERO_RST  = 16'h899F;
    localparam code_t PATTERN_ONE_RST   = 16'hE588;
    localparam code_t PATTERN_TWO_RST   = 16'hED70;
    localparam code_t PATTERN_THREE_RST = 16'hF054;
    localparam dist_t MAX_DISTANCE_RST  = 5'd4;
    localparam dist_t DIST_MAX          = 5'd16;

    // one clockwise quarter turn: cell (r,c) moves to (c,3-r)
    function automatic code_t rotate_cw(input code_t w);
        code_t res;
        res = '0;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                res[c*4 + (3-r)] = w[r*4 + c];
            end
        end
        return res;
    endfunction

    // adder tree popcount
    function automatic dist_t ones16(input code_t w);
        logic [1:0] s1 [8];
        logic [2:0] s2 [4];
        logic [3:0] s3 [2];
        for (int i = 0; i < 8; i++)
        begin
            s1[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        end
        return {1'b0, s3[0]} + {1'b0, s3[1]};
    endfunction

endpackage

// File: rtl/marker_code_rotation_matcher_core.sv
// ----------------------------------------------------------------------------
// marker_code_rotation_matcher_core
// matches a sampled 4x4 marker code against four pattern words at all four
// rotations and reports the best slot, turn count, distance and match flag
//
// channel   direction  signals
// in        input      in_valid, in_ready, cell_bits
// out       output     out_valid, out_ready, matched, pattern_slot,
//                      rotations, distance
// cfg       input      cfg_valid, cfg_ready, cfg_index, cfg_data
//
// one code per cycle sustained while the result side is not stalled; a code is
// held in the input register, then in the result register, and its result is
// valid once it sits in the result register
// the sixteen popcounts and the min tree sit between those two registers
// reset loads the pattern words and limit with their defaults, clears valids
// a stalled result holds the result register; the input register keeps
// taking a code while it is empty or the result register can move
// cfg_ready is always high; indexes above the register list are ignored
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "marker_code_rotation_matcher_core_macros.svh"

module marker_code_rotation_matcher_core
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  mcrm_pkg::code_t          cell_bits,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     matched,
    output mcrm_pkg::slot_t          pattern_slot,
    output mcrm_pkg::turn_t          rotations,
    output mcrm_pkg::dist_t          distance,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  mcrm_pkg::cfg_idx_t       cfg_index,
    input  logic [15:0]              cfg_data
);
    import mcrm_pkg::*;

    code_t pattern_reg [SlotCount];
    dist_t max_distance_reg;

    logic  stage_valid_reg;
    code_t code_reg;
    logic  out_valid_reg;
    logic  matched_reg;
    slot_t slot_reg;
    turn_t turn_reg;
    dist_t dist_reg;

    logic  advance;
    code_t probe [TurnCount];
    dist_t dist_l0 [CandCount];
    cand_t idx_l0  [CandCount];
    dist_t dist_l1 [CandCount/2];
    cand_t idx_l1  [CandCount/2];
    dist_t dist_l2 [CandCount/4];
    cand_t idx_l2  [CandCount/4];
    dist_t dist_l3 [CandCount/8];
    cand_t idx_l3  [CandCount/8];
    dist_t best_dist;
    cand_t best_idx;

    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg[0]   <= PATTERN_ZERO_RST;
            pattern_reg[1]   <= PATTERN_ONE_RST;
            pattern_reg[2]   <= PATTERN_TWO_RST;
            pattern_reg[3]   <= PATTERN_THREE_RST;
            max_distance_reg <= MAX_DISTANCE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PATTERN_ZERO:  pattern_reg[0]   <= cfg_data;
                REG_PATTERN_ONE:   pattern_reg[1]   <= cfg_data;
                REG_PATTERN_TWO:   pattern_reg[2]   <= cfg_data;
                REG_PATTERN_THREE: pattern_reg[3]   <= cfg_data;
                REG_MAX_DISTANCE:  max_distance_reg <= cfg_data[DistWidth-1:0];
                default:           ;
            endcase
        end
    end

    // pipeline handshake
    assign advance   = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stage_valid_reg || advance;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            code_reg <= cell_bits;
        end
    end

    // distances for every slot and turn, candidate index = slot * 4 + turn
    always_comb
    begin
        probe[0] = code_reg;
        for (int t = 1; t < TurnCount; t++)
        begin
            probe[t] = rotate_cw(probe[t-1]);
        end
        for (int s = 0; s < SlotCount; s++)
        begin
            for (int t = 0; t < TurnCount; t++)
            begin
                dist_l0[s*TurnCount + t] = ones16(probe[t] ^ pattern_reg[s]);
                idx_l0[s*TurnCount + t]  = CandWidth'(s*TurnCount + t);
            end
        end
    end

    // min tree, the lower index wins on a tie
    always_comb
    begin
        for (int i = 0; i < CandCount/2; i++)
        begin
            if (dist_l0[2*i+1] < dist_l0[2*i])
            begin
                dist_l1[i] = dist_l0[2*i+1];
                idx_l1[i]  = idx_l0[2*i+1];
            end
            else
            begin
                dist_l1[i] = dist_l0[2*i];
                idx_l1[i]  = idx_l0[2*i];
            end
        end
        for (int i = 0; i < CandCount/4; i++)
        begin
            if (dist_l1[2*i+1] < dist_l1[2*i])
            begin
                dist_l2[i] = dist_l1[2*i+1];
                idx_l2[i]  = idx_l1[2*i+1];
            end
            else
            begin
                dist_l2[i] = dist_l1[2*i];
                idx_l2[i]  = idx_l1[2*i];
            end
        end
        for (int i = 0; i < CandCount/8; i++)
        begin
            if (dist_l2[2*i+1] < dist_l2[2*i])
            begin
                dist_l3[i] = dist_l2[2*i+1];
                idx_l3[i]  = idx_l2[2*i+1];
            end
            else
            begin
                dist_l3[i] = dist_l2[2*i];
                idx_l3[i]  = idx_l2[2*i];
            end
        end
        if (dist_l3[1] < dist_l3[0])
        begin
            best_dist = dist_l3[1];
            best_idx  = idx_l3[1];
        end
        else
        begin
            best_dist = dist_l3[0];
            best_idx  = idx_l3[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            matched_reg <= (best_dist <= max_distance_reg);
            slot_reg    <= best_idx[CandWidth-1:TurnWidth];
            turn_reg    <= best_idx[TurnWidth-1:0];
            dist_reg    <= best_dist;
        end
    end

    assign matched      = matched_reg;
    assign pattern_slot = slot_reg;
    assign rotations    = turn_reg;
    assign distance     = dist_reg;

    `MCRM_ASSERT_NEXT(a_in_to_stage, clk, rst_n, in_valid && in_ready, stage_valid_reg)
    `MCRM_ASSERT_NEXT(a_stage_to_out, clk, rst_n, advance, out_valid_reg)
    `MCRM_ASSERT_SAME(a_dist_range, clk, rst_n, out_valid, distance <= DIST_MAX)
    `MCRM_ASSERT_SAME(a_match_flag, clk, rst_n, out_valid && !cfg_valid,
        matched == (distance <= max_distance_reg))

endmodule

// File: verif/marker_match_checker.sv
// ----------------------------------------------------------------------------
// marker_match_checker
// watches the code, result and register channels of the marker matcher,
// predicts the best slot, turn count, distance and match flag of every
// accepted code and compares each result transfer with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module marker_match_checker
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    input  logic               in_ready,
    input  mcrm_pkg::code_t    cell_bits,

    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               matched,
    input  mcrm_pkg::slot_t    pattern_slot,
    input  mcrm_pkg::turn_t    rotations,
    input  mcrm_pkg::dist_t    distance,

    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  mcrm_pkg::cfg_idx_t cfg_index,
    input  logic [15:0]        cfg_data,

    output int unsigned        fail_count,
    output int unsigned        pending_count
);
    import mcrm_pkg::*;

    typedef struct packed {
        logic  matched;
        slot_t slot;
        turn_t turns;
        dist_t hamming;
    } match_t;

    code_t       slot_code [SlotCount];
    dist_t       accept_limit;
    match_t      expected_matches [$];
    int unsigned result_index;

    // cell (r,c) goes to (c,3-r)
    function automatic code_t quarter_turn(input code_t w);
        code_t res;
        res = '0;
        for (int i = 0; i < CodeWidth; i++)
        begin
            res[(i % 4) * 4 + 3 - i / 4] = w[i];
        end
        return res;
    endfunction

    // first strict minimum in slot order, then turn order
    function automatic match_t best_match(input code_t code);
        match_t      best;
        code_t       probe;
        int unsigned d;
        int unsigned best_dist;
        best      = '0;
        best_dist = CodeWidth + 1;
        for (int s = 0; s < SlotCount; s++)
        begin
            probe = code;
            for (int t = 0; t < TurnCount; t++)
            begin
                d = $countones(probe ^ slot_code[s]);
                if (d < best_dist)
                begin
                    best_dist  = d;
                    best.slot  = slot_t'(s);
                    best.turns = turn_t'(t);
                end
                probe = quarter_turn(probe);
            end
        end
        best.hamming = dist_t'(best_dist);
        best.matched = (best_dist <= accept_limit);
        return best;
    endfunction

    task automatic report(input string what, input match_t want, input match_t got);
        fail_count++;
        if (fail_count <= 10)
        begin
            $write("[%0t] result %0d %s: expected matched=%0b slot=%0d rot=%0d dist=%0d",
                   $time, result_index, what, want.matched, want.slot, want.turns,
                   want.hamming);
            $display(", got matched=%0b slot=%0d rot=%0d dist=%0d",
                     got.matched, got.slot, got.turns, got.hamming);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        match_t got;
        match_t want;
        if (!rst_n)
        begin
            slot_code[0] = PATTERN_ZERO_RST;
            slot_code[1] = PATTERN_ONE_RST;
            slot_code[2] = PATTERN_TWO_RST;
            slot_code[3] = PATTERN_THREE_RST;
            accept_limit = MAX_DISTANCE_RST;
            expected_matches.delete();
            fail_count    = 0;
            pending_count = 0;
            result_index  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PATTERN_ZERO:  slot_code[0] = cfg_data;
                    REG_PATTERN_ONE:   slot_code[1] = cfg_data;
                    REG_PATTERN_TWO:   slot_code[2] = cfg_data;
                    REG_PATTERN_THREE: slot_code[3] = cfg_data;
                    REG_MAX_DISTANCE:  accept_limit = cfg_data[DistWidth-1:0];
                    default:           ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                expected_matches = {expected_matches, best_match(cell_bits)};
            end
            if (out_valid && out_ready)
            begin
                got = {matched, pattern_slot, rotations, distance};
                if (expected_matches.size() == 0)
                begin
                    report("with no code pending", '0, got);
                end
                else
                begin
                    want = expected_matches.pop_front();
                    if (got !== want)
                    begin
                        report("mismatch", want, got);
                    end
                end
                result_index++;
            end
            pending_count = expected_matches.size();
        end
    end

endmodule

// File: verif/tb_marker_code_rotation_matcher_core.sv
// ----------------------------------------------------------------------------
// tb_marker_code_rotation_matcher_core
// drives marker codes and pattern register writes into the matcher with
// random gaps and result stalls; directed corner codes first, then phases of
// random codes, mostly rotated and corrupted copies of the loaded patterns,
// under several pattern sets and match limits including the extremes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_marker_code_rotation_matcher_core;
    import mcrm_pkg::*;

    localparam int unsigned CycleLimit    = 400000;
    localparam int          PhaseCodes    = 80;
    localparam cfg_idx_t    IDX_UNUSED_LO = 3'd5;
    localparam cfg_idx_t    IDX_UNUSED_HI = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    code_t       cell_bits;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        matched;
    slot_t       pattern_slot;
    turn_t       rotations;
    dist_t       distance;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_idx_t    cfg_index;
    logic [15:0] cfg_data;

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned cycle_count;
    int unsigned stall_left;
    code_t       loaded_code [SlotCount];

    marker_code_rotation_matcher_core u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cell_bits    (cell_bits),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .matched      (matched),
        .pattern_slot (pattern_slot),
        .rotations    (rotations),
        .distance     (distance),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    marker_match_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cell_bits     (cell_bits),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .matched       (matched),
        .pattern_slot  (pattern_slot),
        .rotations     (rotations),
        .distance      (distance),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // gap before a code transfer; one window in four has none
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (((cycle_count / 500) % 4) == 1 || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned pick_stall();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 50);
    endfunction

    // result side back-pressure; no new stall starts in one window in four
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (((cycle_count / 500) % 4) != 3 && $urandom_range(0, 99) < 25)
        begin
            stall_left <= pick_stall();
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic push_code(input code_t code);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        cell_bits <= code;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_count != 0);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
        if (idx <= REG_PATTERN_THREE)
            loaded_code[idx[SlotWidth-1:0]] = data;
    endtask

    task automatic load_config(input code_t p0, input code_t p1, input code_t p2,
                               input code_t p3, input logic [15:0] limit_data);
        for (int i = IDX_UNUSED_LO; i <= IDX_UNUSED_HI; i++)
        begin
            write_reg(cfg_idx_t'(i), 16'($urandom));
        end
        write_reg(REG_PATTERN_ZERO, p0);
        write_reg(REG_PATTERN_ONE, p1);
        write_reg(REG_PATTERN_TWO, p2);
        write_reg(REG_PATTERN_THREE, p3);
        write_reg(REG_MAX_DISTANCE, limit_data);
    endtask

    // mostly turned and corrupted copies of a loaded pattern
    function automatic code_t next_code();
        int unsigned r;
        int unsigned s;
        code_t       w;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            s = $urandom_range(0, SlotCount - 1);
            w = loaded_code[s];
            repeat ($urandom_range(0, TurnCount - 1)) w = rotate_cw(w);
            repeat ($urandom_range(0, 5)) w[$urandom_range(0, CodeWidth - 1)] ^= 1'b1;
            return w;
        end
        if (r < 85)
            return code_t'($urandom);
        if (r < 93)
            return code_t'($urandom & $urandom & $urandom);
        return code_t'($urandom | $urandom | $urandom);
    endfunction

    task automatic run_random(input int count);
        repeat (count) push_code(next_code());
        drain();
    endtask

    initial
    begin : stimulus
        code_t w;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        cell_bits   = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_PATTERN_ZERO;
        cfg_data    = '0;
        loaded_code[0] = PATTERN_ZERO_RST;
        loaded_code[1] = PATTERN_ONE_RST;
        loaded_code[2] = PATTERN_TWO_RST;
        loaded_code[3] = PATTERN_THREE_RST;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // corner codes and every pattern at every turn under reset registers
        push_code(16'h0000);
        push_code(16'hFFFF);
        push_code(16'h0001);
        push_code(16'h8000);
        push_code(16'hAAAA);
        push_code(16'h5555);
        for (int s = 0; s < SlotCount; s++)
        begin
            for (int t = 0; t < TurnCount; t++)
            begin
                w = loaded_code[s];
                repeat (t) w = rotate_cw(w);
                push_code(w);
            end
        end
        run_random(PhaseCodes);

        // zero limit, extreme patterns
        load_config(16'h0000, 16'hFFFF, 16'h00FF, 16'h0F0F, 16'h0000);
        run_random(PhaseCodes);

        // turn-symmetric pattern in every slot: ties across slots and turns
        load_config(16'h9669, 16'h9669, 16'h9669, 16'h9669, 16'd16);
        run_random(PhaseCodes);

        // equal random patterns, limit beyond any distance
        w = code_t'($urandom);
        load_config(w, w, w, w, 16'hFFFF);
        run_random(PhaseCodes);

        load_config(code_t'($urandom), code_t'($urandom), code_t'($urandom),
                    code_t'($urandom), {11'($urandom), 5'd17});
        run_random(PhaseCodes);

        repeat (3)
        begin
            load_config(code_t'($urandom), code_t'($urandom), code_t'($urandom),
                        code_t'($urandom), 16'($urandom));
            run_random(PhaseCodes);
        end

        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
